>>> sv/dmt_pkg.sv
// shared types, constants and rounding helpers of the detection marker tracker
package dmt_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int COORD_BITS_DEF = 12;
  localparam int LIFE_W         = 9;
  localparam int LIFETIME_W     = 8;
  localparam int COUNT_W        = 8;
  localparam int SLOT_IDX_W     = 4;
  localparam int CMD_W          = 2;
  localparam int HALF_W         = 18;

  localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = 8'd5;
  localparam logic [LIFETIME_W-1:0] LIFETIME_MIN   = 8'd2;
  localparam logic [COUNT_W-1:0]    COUNT_MAX      = 8'd255;

  localparam logic KIND_MARKER = 1'b0;
  localparam logic KIND_COUNT  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_FRAME_START = 2'd0,
    CMD_DETECT      = 2'd1,
    CMD_FRAME_END   = 2'd2,
    CMD_CLEAR       = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // bits rounded up to whole bytes
  function automatic int bytes_up(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

  // round(s / 2), ties to even
  function automatic logic [HALF_W-1:0] half_even2(input logic [HALF_W-1:0] s);
    logic [HALF_W-1:0] q;
    q = s >> 1;
    if (s[0] && q[0]) begin
      q = q + HALF_W'(1);
    end
    return q;
  endfunction

  // round(t / 4), ties to even
  function automatic logic [HALF_W-1:0] half_even4(input logic [HALF_W-1:0] t);
    logic [HALF_W-1:0] q;
    q = t >> 2;
    if ((t[1:0] == 2'd3) || ((t[1:0] == 2'd2) && q[0])) begin
      q = q + HALF_W'(1);
    end
    return q;
  endfunction

endpackage

>>> sv/detection_marker_tracker.sv
// top level of the detection marker tracker: command sequencer, slot scan and result register
//
// Keeps SLOT_COUNT marker slots (centre and lifetime in one ram, occupied bits in flops) and
// takes one command per transaction on the in_ stream: frame start ages the occupied slots,
// a detection gets its rounded centre and radius and refreshes the first occupied slot within
// the radius or else takes the first free slot, frame end frees expired slots and reports the
// saturating detection count, and clear frees every slot at acceptance, with no scan. Frame start,
// detection and frame end each walk every slot once through the single ram read port, one slot
// per cycle: a detection has its result after the scan, the last distance test and the slot
// update; frame end has its result after the scan; frame start is ready again after the scan
// and the last aging write. A result also waits while the output register still holds an
// earlier one. Input is accepted only between commands, while a finished result may still sit
// in the output register. The lifetime register is written with cfg_we; values below 2 are
// ignored.
module detection_marker_tracker #(
  parameter int SLOT_COUNT = dmt_pkg::SLOT_COUNT_DEF,
  parameter int COORD_BITS = dmt_pkg::COORD_BITS_DEF,
  localparam int IN_W      = dmt_pkg::bytes_up(4 * COORD_BITS),
  localparam int OUT_W     = dmt_pkg::bytes_up(3 * COORD_BITS + 15)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,  // rect_x, rect_y, rect_w, rect_h, zero fill
  input  logic [dmt_pkg::CMD_W-1:0]         in_tuser,  // command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [OUT_W-1:0]                  out_tdata, // slot_index, table_full, center_x,
                                                       // center_y, radius, frame_count, zero fill
  output logic                              out_tuser, // result_kind
  input  logic                              cfg_we,
  input  logic [dmt_pkg::LIFETIME_W-1:0]    cfg_wdata
);

  import dmt_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int CW     = CB + 1;
  localparam int IW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int WORD_W = LIFE_W + 2 * CW;
  localparam int R2_W   = 2 * CB;
  localparam int PAY_W  = SLOT_IDX_W + 1 + 2 * CW + CB + COUNT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r;
  logic [LIFETIME_W-1:0] lifetime_r;
  logic [COUNT_W-1:0]   det_r;
  logic [SLOT_COUNT-1:0] used_r;

  logic [CW-1:0]        cx_r, cy_r;
  logic [CB-1:0]        rad_r;
  logic [R2_W-1:0]      r2_r;
  logic [CW-1:0]        cx_nxt, cy_nxt;
  logic [CB-1:0]        rad_nxt;

  logic [IW-1:0]        scan_idx_r;
  logic                 p1_v_r;
  logic                 p1_used_r;
  logic [IW-1:0]        p1_idx_r;

  logic                 match_r;
  logic [IW-1:0]        match_idx_r;
  logic                 free_found_r;
  logic [IW-1:0]        free_idx_r;
  logic                 res_full_r;
  logic [IW-1:0]        res_idx_r;

  logic                 out_tvalid_r;
  logic [OUT_W-1:0]     out_tdata_r;
  logic                 out_tuser_r;

  logic                 accept;
  logic                 emit_load;
  logic                 scan_step;
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WORD_W-1:0]    ram_rdata;
  logic [CW-1:0]        slot_x, slot_y;
  logic [LIFE_W-1:0]    slot_life;
  logic                 hit_v;
  logic [IW-1:0]        hit_idx;
  logic                 dist_busy;
  logic [IW-1:0]        upd_idx;
  logic                 upd_ok;
  logic [PAY_W-1:0]     payload;

  cmd_t                 in_cmd;
  logic [CB-1:0]        in_x, in_y, in_w, in_h;

  assign in_cmd = cmd_t'(in_tuser);
  assign in_x   = in_tdata[CB-1:0];
  assign in_y   = in_tdata[2*CB-1:CB];
  assign in_w   = in_tdata[3*CB-1:2*CB];
  assign in_h   = in_tdata[4*CB-1:3*CB];

  // centre and radius, rounded half to even
  assign cx_nxt  = CW'(half_even2((HALF_W'(in_x) << 1) + HALF_W'(in_w)));
  assign cy_nxt  = CW'(half_even2((HALF_W'(in_y) << 1) + HALF_W'(in_h)));
  assign rad_nxt = CB'(half_even4(HALF_W'(in_w) + HALF_W'(in_h)));

  assign slot_x    = ram_rdata[CW-1:0];
  assign slot_y    = ram_rdata[2*CW-1:CW];
  assign slot_life = ram_rdata[WORD_W-1:2*CW];

  assign accept = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd != CMD_CLEAR)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_v_r && !dist_busy) begin
          unique case (cmd_r)
            CMD_DETECT:      state_nxt = ST_UPDATE;
            CMD_FRAME_END:   state_nxt = ST_EMIT;
            default:         state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign upd_ok  = match_r || free_found_r;
  assign upd_idx = match_r ? match_idx_r : free_idx_r;

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    scan_step = 1'b0;
    emit_load = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = p1_idx_r;
    ram_wdata = {slot_life - LIFE_W'(1), slot_y, slot_x};
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_SCAN: begin
        scan_step = 1'b1;
      end
      ST_UPDATE: begin
        ram_we    = upd_ok;
        ram_waddr = upd_idx;
        ram_wdata = {LIFE_W'(lifetime_r), cy_r, cx_r};
      end
      ST_EMIT: begin
        emit_load = !out_tvalid_r || out_tready;
      end
      default: begin
      end
    endcase
    // frame start ages an occupied slot as its word comes back
    if (p1_v_r && (cmd_r == CMD_FRAME_START) && p1_used_r && !slot_life[LIFE_W-1]) begin
      ram_we = 1'b1;
    end
  end

  dmt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  dmt_dist #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IW)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .probe_v   (p1_v_r && p1_used_r && (cmd_r == CMD_DETECT)),
    .probe_idx (p1_idx_r),
    .cx        (cx_r),
    .cy        (cy_r),
    .sx        (slot_x),
    .sy        (slot_y),
    .r2        (r2_r),
    .hit_v     (hit_v),
    .hit_idx   (hit_idx),
    .busy      (dist_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cmd_r        <= CMD_FRAME_START;
      lifetime_r   <= LIFETIME_RESET;
      det_r        <= '0;
      used_r       <= '0;
      scan_idx_r   <= '0;
      p1_v_r       <= 1'b0;
      match_r      <= 1'b0;
      free_found_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p1_v_r  <= scan_step;

      if (cfg_we && (cfg_wdata >= LIFETIME_MIN)) begin
        lifetime_r <= cfg_wdata;
      end

      if (accept) begin
        cmd_r        <= in_cmd;
        scan_idx_r   <= '0;
        match_r      <= 1'b0;
        free_found_r <= 1'b0;
        case (in_cmd)
          CMD_FRAME_START: det_r  <= '0;
          CMD_DETECT:      det_r  <= (det_r == COUNT_MAX) ? det_r : det_r + COUNT_W'(1);
          CMD_CLEAR:       used_r <= '0;
          default: begin
          end
        endcase
      end

      if (scan_step) begin
        if (scan_idx_r != LAST_IDX) begin
          scan_idx_r <= scan_idx_r + IW'(1);
        end
        if (!used_r[scan_idx_r] && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end

      // first match in slot order wins
      if (hit_v && !match_r) begin
        match_r <= 1'b1;
      end

      if (p1_v_r && (cmd_r == CMD_FRAME_END) && p1_used_r && slot_life[LIFE_W-1]) begin
        used_r[p1_idx_r] <= 1'b0;
      end

      if ((state_r == ST_UPDATE) && upd_ok) begin
        used_r[upd_idx] <= 1'b1;
      end

      if (emit_load) begin
        out_tvalid_r <= 1'b1;
        if (cmd_r == CMD_FRAME_END) begin
          det_r <= '0;
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    r2_r <= R2_W'(rad_r) * R2_W'(rad_r);
    if (accept) begin
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      rad_r <= rad_nxt;
    end
    if (scan_step) begin
      p1_idx_r  <= scan_idx_r;
      p1_used_r <= used_r[scan_idx_r];
      if (!used_r[scan_idx_r] && !free_found_r) begin
        free_idx_r <= scan_idx_r;
      end
    end
    if (hit_v && !match_r) begin
      match_idx_r <= hit_idx;
    end
    if (state_r == ST_UPDATE) begin
      res_full_r <= !upd_ok;
      res_idx_r  <= upd_ok ? upd_idx : '0;
    end
    if (emit_load) begin
      out_tdata_r <= OUT_W'(payload);
      out_tuser_r <= (cmd_r == CMD_FRAME_END) ? KIND_COUNT : KIND_MARKER;
    end
  end

  always_comb begin
    if (cmd_r == CMD_FRAME_END) begin
      payload = {det_r, {(PAY_W - COUNT_W){1'b0}}};
    end else begin
      payload = {COUNT_W'(0), rad_r, cy_r, cx_r, res_full_r, SLOT_IDX_W'(res_idx_r)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

>>> sv/dmt_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module dmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/dmt_dist.sv
// distance test stage: squares the offsets to one slot, then compares with radius squared
module dmt_dist #(
  parameter int COORD_BITS = 12,
  parameter int IDX_W      = 4,
  localparam int CW        = COORD_BITS + 1,
  localparam int SQ_W      = 2 * CW,
  localparam int SUM_W     = SQ_W + 1,
  localparam int R2_W      = 2 * COORD_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             probe_v,
  input  logic [IDX_W-1:0] probe_idx,
  input  logic [CW-1:0]    cx,
  input  logic [CW-1:0]    cy,
  input  logic [CW-1:0]    sx,
  input  logic [CW-1:0]    sy,
  input  logic [R2_W-1:0]  r2,
  output logic             hit_v,
  output logic [IDX_W-1:0] hit_idx,
  output logic             busy
);

  logic [CW-1:0]    adx;
  logic [CW-1:0]    ady;
  logic             sq_v_r;
  logic [IDX_W-1:0] sq_idx_r;
  logic [SQ_W-1:0]  sqx_r;
  logic [SQ_W-1:0]  sqy_r;
  logic [SUM_W-1:0] d2;

  assign adx = (cx >= sx) ? (cx - sx) : (sx - cx);
  assign ady = (cy >= sy) ? (cy - sy) : (sy - cy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else begin
      sq_v_r <= probe_v;
    end
  end

  always_ff @(posedge clk) begin
    sq_idx_r <= probe_idx;
    sqx_r    <= SQ_W'(adx) * SQ_W'(adx);
    sqy_r    <= SQ_W'(ady) * SQ_W'(ady);
  end

  assign d2      = SUM_W'(sqx_r) + SUM_W'(sqy_r);
  assign hit_v   = sq_v_r && (d2 <= SUM_W'(r2));
  assign hit_idx = sq_idx_r;
  assign busy    = sq_v_r;

endmodule
